### design/pbez_pkg.sv
// Shared constants for the piecewise cubic Bezier evaluator: field widths,
// action and status codes, register map and default sizes.
// No dependencies.
package pbez_pkg;

  // Default sizes handed to the top level parameters
  localparam int MAX_POINTS_DEF = 64;
  localparam int MAX_DIMS_DEF   = 4;
  localparam int FRAC_BITS_DEF  = 16;

  // Field widths
  localparam int COORD_W    = 32;
  localparam int NUM_COORDS = 4;
  localparam int U_W        = 17;
  localparam int U_FRAC     = 16;
  localparam int ACTION_W   = 2;
  localparam int STATUS_W   = 2;
  localparam int DIMS_W     = 3;

  localparam logic [U_W-1:0]    U_ONE      = 17'h10000;
  localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd3;

  // Actions
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_POS    = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_TAN    = 2'd3;

  // Result status
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOSEG = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // APB register map: register index is paddr[2]
  localparam int          APB_ADDR_W = 3;
  localparam int          APB_DATA_W = 32;
  localparam logic [0:0]  REG_DIMS   = 1'b0;

endpackage

### design/piecewise_cubic_bezier_eval.sv
// Piecewise cubic Bezier evaluator: control point table, weight sequencer and
// shared-multiplier dot product. Uses pbez_pkg and pbez_ram.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------
//  input    | in_valid_i / in_ready_o | action_i, param_u_i, coord_0_i..3_i
//  result   | out_valid_o/out_ready_i | status_o, out_0_o..out_3_o
//  config   | psel/penable/pwrite     | paddr, pwdata, prdata (pready tied 1)
//
// The single 32 x (FRAC_BITS+3) multiplier computes one product per cycle
// for u*segments, the Bernstein terms and every point*weight term.
// A new transaction is taken in the cycle after the previous result is loaded
// into the output register; that register holds while out_ready_i is low.
// Reset clears the point and segment counts; the point table needs no pass.
module piecewise_cubic_bezier_eval #(
  parameter int MAX_POINTS = pbez_pkg::MAX_POINTS_DEF,
  parameter int MAX_DIMS   = pbez_pkg::MAX_DIMS_DEF,
  parameter int FRAC_BITS  = pbez_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [pbez_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [pbez_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [pbez_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready,
  // input channel
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [pbez_pkg::ACTION_W-1:0]         action_i,
  input  logic [pbez_pkg::U_W-1:0]              param_u_i,
  input  logic signed [pbez_pkg::COORD_W-1:0]   coord_0_i,
  input  logic signed [pbez_pkg::COORD_W-1:0]   coord_1_i,
  input  logic signed [pbez_pkg::COORD_W-1:0]   coord_2_i,
  input  logic signed [pbez_pkg::COORD_W-1:0]   coord_3_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [pbez_pkg::STATUS_W-1:0]         status_o,
  output logic signed [pbez_pkg::COORD_W-1:0]   out_0_o,
  output logic signed [pbez_pkg::COORD_W-1:0]   out_1_o,
  output logic signed [pbez_pkg::COORD_W-1:0]   out_2_o,
  output logic signed [pbez_pkg::COORD_W-1:0]   out_3_o
);

  import pbez_pkg::*;

  // ---------------------------------------------------------------------------
  // Derived sizes
  // ---------------------------------------------------------------------------
  localparam int ADDR_W   = $clog2(MAX_POINTS);
  localparam int PC_W     = $clog2(MAX_POINTS + 1);
  localparam int MAX_SEGS = (MAX_POINTS - 1) / 3;
  localparam int SEG_W    = $clog2(MAX_SEGS + 1);
  localparam int T_W      = FRAC_BITS + 1;       // t, s, t2, s2 in [0, ONE]
  localparam int WB       = FRAC_BITS + 3;       // signed weights, |w| <= 3*ONE
  localparam int TW       = WB + 3;              // tangent weight intermediates
  localparam int PROD_W   = COORD_W + WB;
  localparam int ACC_W    = PROD_W + 2;          // sum of four products
  localparam int SC_W     = U_W + SEG_W;         // u * segments
  localparam int ROW_W    = MAX_DIMS * COORD_W;
  localparam int LSH      = (FRAC_BITS >= U_FRAC) ? FRAC_BITS - U_FRAC : 0;
  localparam int RSH      = (FRAC_BITS < U_FRAC) ? U_FRAC - FRAC_BITS : 0;
  localparam int CONV_W   = U_W + LSH;
  localparam int CNT_W    = PC_W + 2;

  localparam logic [T_W-1:0]          ONE_T     = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [TW-1:0]    THREE_ONE = TW'(3 * (1 << FRAC_BITS));
  localparam logic signed [ACC_W-1:0] SAT_HI    = ACC_W'(2147483647);
  localparam logic signed [ACC_W-1:0] SAT_LO    = ~SAT_HI;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCALE = 3'd1;
  localparam logic [2:0] S_SPLIT = 3'd2;
  localparam logic [2:0] S_WGT   = 3'd3;
  localparam logic [2:0] S_TAN   = 3'd4;
  localparam logic [2:0] S_MAC   = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  // Weight steps, issued in this order
  localparam logic [2:0] WS_TT = 3'd0;
  localparam logic [2:0] WS_SS = 3'd1;
  localparam logic [2:0] WS_B3 = 3'd2;
  localparam logic [2:0] WS_B0 = 3'd3;
  localparam logic [2:0] WS_B1 = 3'd4;
  localparam logic [2:0] WS_B2 = 3'd5;

  // Destination of the product register
  localparam logic [2:0] TAG_NONE = 3'd0;
  localparam logic [2:0] TAG_T2   = 3'd1;
  localparam logic [2:0] TAG_S2   = 3'd2;
  localparam logic [2:0] TAG_B0   = 3'd3;
  localparam logic [2:0] TAG_B1   = 3'd4;
  localparam logic [2:0] TAG_B2   = 3'd5;
  localparam logic [2:0] TAG_B3   = 3'd6;
  localparam logic [2:0] TAG_ACC  = 3'd7;

  // ---------------------------------------------------------------------------
  // Signals
  // ---------------------------------------------------------------------------
  logic [2:0]              state_q, state_d;
  logic [2:0]              step_q, step_d;
  logic [1:0]              pt_q, pt_d;
  logic [1:0]              dim_q, dim_d;
  logic [2:0]              tag_q, tag_d;
  logic [1:0]              acc_sel_q, acc_sel_d;
  logic [PC_W-1:0]         pc_q, pc_d;
  logic [SEG_W-1:0]        seg_q, seg_d;
  logic [DIMS_W-1:0]       dims_q;
  logic [DIMS_W-1:0]       dims_eff;
  logic [ADDR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [STATUS_W-1:0]     res_st_q, res_st_d;
  logic [U_W-1:0]          u_q;
  logic                    tan_q;
  logic                    out_valid_q;
  logic                    in_acc;
  logic                    fin_load;
  logic                    cfg_wr;

  // shared multiplier
  logic signed [COORD_W-1:0] mul_a;
  logic signed [WB-1:0]      mul_b;
  logic signed [PROD_W-1:0]  prod_q;

  // weight datapath
  logic [T_W-1:0]          t_q, s_q, t2_q, s2_q;
  logic signed [WB-1:0]    w_q [NUM_COORDS];
  logic signed [ACC_W-1:0] acc_q [NUM_COORDS];

  // point table
  logic                    ram_we, ram_re;
  logic [ROW_W-1:0]        ram_wdata, ram_rdata;
  logic signed [COORD_W-1:0] coord_in [NUM_COORDS];
  logic signed [COORD_W-1:0] coord_rd [NUM_COORDS];

  // segment bookkeeping
  logic [CNT_W-1:0]        seg_x, seg_at, pc_x;
  logic                    seg_hit;

  // split of u * segments
  logic [SC_W-1:0]         scaled;
  logic [SEG_W:0]          k_raw;
  logic                    k_clamp;
  logic [SEG_W-1:0]        k_c;
  logic [U_W-1:0]          t17;
  logic [CONV_W-1:0]       t_conv;
  logic [T_W-1:0]          t_c, s_c;
  logic [ADDR_W+1:0]       k_ext;
  logic [ADDR_W-1:0]       base_c;
  logic [U_W-1:0]          u_clamp;

  // tangent weights
  logic signed [TW-1:0]    tt, tt2, six_t, twelve_t, three_t2, nine_t2;
  logic signed [TW-1:0]    tw0, tw1, tw2, tw3;
  logic signed [WB-1:0]    wx;

  // result
  logic signed [COORD_W-1:0] res [NUM_COORDS];
  logic signed [COORD_W-1:0] out_q [NUM_COORDS];
  logic [STATUS_W-1:0]       status_q;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[APB_ADDR_W-1:2] == REG_DIMS);

  always_comb begin
    prdata = '0;
    if (paddr[APB_ADDR_W-1:2] == REG_DIMS) begin
      prdata = APB_DATA_W'(dims_q);
    end
  end

  // Coordinate counts above the table width act as the table width
  assign dims_eff = (dims_q > DIMS_W'(MAX_DIMS)) ? DIMS_W'(MAX_DIMS) : dims_q;

  // ---------------------------------------------------------------------------
  // Point table: one row per point, all table coordinates written on append
  // ---------------------------------------------------------------------------
  assign coord_in[0] = coord_0_i;
  assign coord_in[1] = coord_1_i;
  assign coord_in[2] = coord_2_i;
  assign coord_in[3] = coord_3_i;

  for (genvar gi = 0; gi < NUM_COORDS; gi++) begin : g_row
    if (gi < MAX_DIMS) begin : g_used
      assign ram_wdata[gi*COORD_W +: COORD_W] = coord_in[gi];
      assign coord_rd[gi] = ram_rdata[gi*COORD_W +: COORD_W];
    end else begin : g_unused
      assign coord_rd[gi] = '0;
    end
  end

  pbez_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_POINTS)
  ) u_pts (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pc_q[ADDR_W-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  // Load the output register once it is empty or being drained
  assign fin_load   = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  assign u_clamp = (param_u_i > U_ONE) ? U_ONE : param_u_i;

  // A new segment closes when the point count reaches 3*segments + 4
  assign seg_x   = CNT_W'(seg_q);
  assign seg_at  = (seg_x << 1) + seg_x + CNT_W'(4);
  assign pc_x    = CNT_W'(pc_q);
  assign seg_hit = ((pc_x + CNT_W'(1)) == seg_at);

  // ---------------------------------------------------------------------------
  // Segment select and local parameter, from the u * segments product
  // ---------------------------------------------------------------------------
  always_comb begin
    scaled  = prod_q[SC_W-1:0];
    k_raw   = scaled[SC_W-1:U_FRAC];
    // Only u equal to one lands past the last segment: use it with t = ONE
    k_clamp = (k_raw >= {1'b0, seg_q});
    k_c     = k_clamp ? (seg_q - SEG_W'(1)) : k_raw[SEG_W-1:0];
    t17     = k_clamp ? U_ONE : {1'b0, scaled[U_FRAC-1:0]};
    t_conv  = (CONV_W'(t17) << LSH) >> RSH;
    t_c     = t_conv[T_W-1:0];
    s_c     = ONE_T - t_c;
    k_ext   = (ADDR_W+2)'(k_c);
    base_c  = ADDR_W'((k_ext << 1) + k_ext);
  end

  // ---------------------------------------------------------------------------
  // Tangent weights: shift-and-add of t and t^2
  // ---------------------------------------------------------------------------
  always_comb begin
    tt       = TW'(t_q);
    tt2      = TW'(t2_q);
    six_t    = (tt <<< 2) + (tt <<< 1);
    twelve_t = six_t <<< 1;
    three_t2 = (tt2 <<< 1) + tt2;
    nine_t2  = (tt2 <<< 3) + tt2;
    tw0      = six_t - three_t2 - THREE_ONE;
    tw1      = THREE_ONE - twelve_t + nine_t2;
    tw2      = six_t - nine_t2;
    tw3      = three_t2;
  end

  // Bernstein term from the product register, floored to Q.FRAC_BITS
  assign wx = prod_q[FRAC_BITS +: WB];

  // ---------------------------------------------------------------------------
  // Sequencer: drives the shared multiplier and the table read port
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    pt_d      = pt_q;
    dim_d     = dim_q;
    pc_d      = pc_q;
    seg_d     = seg_q;
    rd_ptr_d  = rd_ptr_q;
    res_st_d  = res_st_q;
    acc_sel_d = acc_sel_q;
    tag_d     = TAG_NONE;
    mul_a     = '0;
    mul_b     = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_st_d = STATUS_OK;
          state_d  = S_FIN;
          unique case (action_i)
            ACT_CLEAR: begin
              pc_d  = '0;
              seg_d = '0;
            end
            ACT_APPEND: begin
              priority if (dims_eff == '0) begin
                // no coordinates: drop the point
              end else if (pc_q >= PC_W'(MAX_POINTS)) begin
                res_st_d = STATUS_FULL;
              end else begin
                ram_we = 1'b1;
                pc_d   = pc_q + PC_W'(1);
                if (seg_hit) begin
                  seg_d = seg_q + SEG_W'(1);
                end
              end
            end
            ACT_POS, ACT_TAN: begin
              if (seg_q == '0) begin
                res_st_d = STATUS_NOSEG;
              end else begin
                state_d = S_SCALE;
              end
            end
          endcase
        end
      end

      S_SCALE: begin
        mul_a   = COORD_W'(u_q);
        mul_b   = WB'(seg_q);
        state_d = S_SPLIT;
      end

      S_SPLIT: begin
        rd_ptr_d = base_c;
        step_d   = WS_TT;
        state_d  = S_WGT;
      end

      S_WGT: begin
        step_d = step_q + 3'd1;
        unique case (step_q)
          WS_TT: begin
            mul_a = COORD_W'(t_q);
            mul_b = WB'(t_q);
            tag_d = TAG_T2;
          end
          WS_SS: begin
            if (tan_q) begin
              // t^2 lands this cycle; tangent weights follow
              state_d = S_TAN;
            end else begin
              mul_a = COORD_W'(s_q);
              mul_b = WB'(s_q);
              tag_d = TAG_S2;
            end
          end
          WS_B3: begin
            mul_a = COORD_W'(t2_q);
            mul_b = WB'(t_q);
            tag_d = TAG_B3;
          end
          WS_B0: begin
            mul_a = COORD_W'(s2_q);
            mul_b = WB'(s_q);
            tag_d = TAG_B0;
          end
          WS_B1: begin
            mul_a = COORD_W'(t_q);
            mul_b = WB'(s2_q);
            tag_d = TAG_B1;
          end
          WS_B2: begin
            mul_a    = COORD_W'(t2_q);
            mul_b    = WB'(s_q);
            tag_d    = TAG_B2;
            ram_re   = 1'b1;
            rd_ptr_d = rd_ptr_q + ADDR_W'(1);
            pt_d     = '0;
            dim_d    = '0;
            state_d  = S_MAC;
          end
          default: begin
            state_d = S_MAC;
          end
        endcase
      end

      S_TAN: begin
        ram_re   = 1'b1;
        rd_ptr_d = rd_ptr_q + ADDR_W'(1);
        pt_d     = '0;
        dim_d    = '0;
        state_d  = S_MAC;
      end

      S_MAC: begin
        if (dims_eff == '0) begin
          state_d = S_DRAIN;
        end else begin
          mul_a     = coord_rd[dim_q];
          mul_b     = w_q[pt_q];
          tag_d     = TAG_ACC;
          acc_sel_d = dim_q;
          if ((DIMS_W'(dim_q) + DIMS_W'(1)) == dims_eff) begin
            dim_d = '0;
            if (pt_q == 2'd3) begin
              state_d = S_DRAIN;
            end else begin
              // fetch the next point while its first term is still pending
              pt_d     = pt_q + 2'd1;
              ram_re   = 1'b1;
              rd_ptr_d = rd_ptr_q + ADDR_W'(1);
            end
          end else begin
            dim_d = dim_q + 2'd1;
          end
        end
      end

      S_DRAIN: begin
        state_d = S_FIN;
      end

      S_FIN: begin
        if (fin_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= WS_TT;
      pt_q        <= '0;
      dim_q       <= '0;
      tag_q       <= TAG_NONE;
      pc_q        <= '0;
      seg_q       <= '0;
      dims_q      <= DIMS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      pt_q    <= pt_d;
      dim_q   <= dim_d;
      tag_q   <= tag_d;
      pc_q    <= pc_d;
      seg_q   <= seg_d;
      if (cfg_wr) begin
        dims_q <= pwdata[DIMS_W-1:0];
      end
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    prod_q    <= mul_a * mul_b;
    rd_ptr_q  <= rd_ptr_d;
    res_st_q  <= res_st_d;
    acc_sel_q <= acc_sel_d;

    if (in_acc) begin
      u_q   <= u_clamp;
      tan_q <= (action_i == ACT_TAN);
    end

    if (state_q == S_SPLIT) begin
      t_q <= t_c;
      s_q <= s_c;
    end

    if (tag_q == TAG_T2) begin
      t2_q <= prod_q[FRAC_BITS +: T_W];
    end
    if (tag_q == TAG_S2) begin
      s2_q <= prod_q[FRAC_BITS +: T_W];
    end

    if (state_q == S_TAN) begin
      w_q[0] <= tw0[WB-1:0];
      w_q[1] <= tw1[WB-1:0];
      w_q[2] <= tw2[WB-1:0];
      w_q[3] <= tw3[WB-1:0];
    end else begin
      unique case (tag_q)
        TAG_B0:  w_q[0] <= wx;
        TAG_B1:  w_q[1] <= (wx <<< 1) + wx;
        TAG_B2:  w_q[2] <= (wx <<< 1) + wx;
        TAG_B3:  w_q[3] <= wx;
        default: ;
      endcase
    end

    // Clear the sums on every transaction; unused coordinates stay zero
    if (in_acc) begin
      for (int i = 0; i < NUM_COORDS; i++) begin
        acc_q[i] <= '0;
      end
    end else if (tag_q == TAG_ACC) begin
      acc_q[acc_sel_q] <= acc_q[acc_sel_q] + ACC_W'(prod_q);
    end

    if (fin_load) begin
      status_q <= res_st_q;
      for (int i = 0; i < NUM_COORDS; i++) begin
        out_q[i] <= res[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Floor by 2^FRAC_BITS and saturate to 32 bits
  // ---------------------------------------------------------------------------
  always_comb begin
    logic signed [ACC_W-1:0] sh;
    for (int i = 0; i < NUM_COORDS; i++) begin
      sh = acc_q[i] >>> FRAC_BITS;
      priority if (sh > SAT_HI) begin
        res[i] = SAT_HI[COORD_W-1:0];
      end else if (sh < SAT_LO) begin
        res[i] = SAT_LO[COORD_W-1:0];
      end else begin
        res[i] = sh[COORD_W-1:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_0_o     = out_q[0];
  assign out_1_o     = out_q[1];
  assign out_2_o     = out_q[2];
  assign out_3_o     = out_q[3];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Segment count tracks the point count: points <= 3*segments+3, and 3*segments+1 <= points once segments > 0
  a_seg_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_x < seg_at) && ((seg_q == '0) || ((pc_x + CNT_W'(3)) >= seg_at)))
    else $error("segment count out of step with point count");

  // Dot-product terms only land while the sums are being built
  a_acc_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tag_q == TAG_ACC) |-> ((state_q == S_MAC) || (state_q == S_DRAIN)))
    else $error("accumulate outside the dot-product window");

  // The coordinate counter stays inside the active coordinates
  a_dim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_MAC) && (dims_eff != '0)) |-> (DIMS_W'(dim_q) < dims_eff))
    else $error("coordinate index beyond active coordinates");

endmodule

### design/pbez_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pbez_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
